// ----- rtl/core/sx7_pkg.sv -----
package sx7_pkg;

    typedef enum logic [2:0] {
        CMD_DATA   = 3'd0,
        CMD_BEGIN  = 3'd1,
        CMD_START  = 3'd2,
        CMD_FLUSH  = 3'd3,
        CMD_RAW    = 3'd4,
        CMD_PACKED = 3'd5,
        CMD_FINISH = 3'd6,
        CMD_CLEAR  = 3'd7
    } t_cmd;

    typedef enum logic [1:0] {
        S_IDLE,
        S_EXEC,
        S_GROUP,
        S_TAIL
    } t_state;

    typedef enum logic [1:0] {
        SRC_RAW,
        SRC_BEGIN,
        SRC_GROUP,
        SRC_TAIL
    } t_src;

    localparam int        GROUP_SIZE  = 7;
    localparam int        CNT_W       = 3;
    localparam int        SUM_W       = 14;
    localparam logic [7:0] BYTE_SOX   = 8'hF0;
    localparam logic [7:0] BYTE_EOX   = 8'hF7;
    localparam logic [SUM_W-1:0] LEN_OFFSET = SUM_W'(5);

    localparam logic [CNT_W-1:0] TAIL_SUM_HI = 3'd0;
    localparam logic [CNT_W-1:0] TAIL_SUM_LO = 3'd1;
    localparam logic [CNT_W-1:0] TAIL_LEN_HI = 3'd2;
    localparam logic [CNT_W-1:0] TAIL_LEN_LO = 3'd3;
    localparam logic [CNT_W-1:0] TAIL_EOX    = 3'd4;

    typedef struct packed {
        logic latch;
        logic store;
        logic emit;
        t_src sel;
        logic last;
        logic cnt_inc;
        logic idx_clr;
        logic group_done;
        logic sum_start;
        logic fin;
        logic set_raw;
        logic set_packed;
        logic clear;
    } t_dp_cmd;

    typedef struct packed {
        t_cmd mode;
        logic packed_mode;
        logic count_zero;
        logic store_full;
        logic grp_end;
        logic tail_end;
        logic slot_free;
    } t_dp_status;

endpackage

// ----- rtl/core/sx7_ctrl.sv -----
module sx7_ctrl (
    input  logic                i_clk,
    input  logic                i_rst_n,
    input  logic                i_valid,
    output logic                o_ready,
    input  sx7_pkg::t_dp_status i_status,
    output sx7_pkg::t_dp_cmd    o_cmd
);

    sx7_pkg::t_state r_state;
    sx7_pkg::t_state n_state;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= sx7_pkg::S_IDLE;
        end else begin
            r_state <= n_state;
        end
    end

    assign o_ready = (r_state == sx7_pkg::S_IDLE);

    always_comb begin
        n_state = r_state;
        o_cmd   = '0;
        unique case (r_state)
            sx7_pkg::S_IDLE: begin
                if (i_valid) begin
                    o_cmd.latch = 1'b1;
                    n_state     = sx7_pkg::S_EXEC;
                end
            end
            sx7_pkg::S_EXEC: begin
                unique case (i_status.mode) inside
                    sx7_pkg::CMD_DATA: begin
                        if (i_status.packed_mode) begin
                            o_cmd.store   = 1'b1;
                            o_cmd.idx_clr = 1'b1;
                            n_state = i_status.store_full ? sx7_pkg::S_GROUP : sx7_pkg::S_IDLE;
                        end else if (i_status.slot_free) begin
                            o_cmd.emit    = 1'b1;
                            o_cmd.sel     = sx7_pkg::SRC_RAW;
                            o_cmd.last    = 1'b1;
                            o_cmd.cnt_inc = 1'b1;
                            n_state       = sx7_pkg::S_IDLE;
                        end
                    end
                    sx7_pkg::CMD_BEGIN: begin
                        if (i_status.slot_free) begin
                            o_cmd.emit    = 1'b1;
                            o_cmd.sel     = sx7_pkg::SRC_BEGIN;
                            o_cmd.last    = 1'b1;
                            o_cmd.cnt_inc = 1'b1;
                            n_state       = sx7_pkg::S_IDLE;
                        end
                    end
                    sx7_pkg::CMD_START: begin
                        o_cmd.sum_start = 1'b1;
                        n_state         = sx7_pkg::S_IDLE;
                    end
                    sx7_pkg::CMD_FLUSH, sx7_pkg::CMD_RAW, sx7_pkg::CMD_PACKED: begin
                        o_cmd.set_raw    = (i_status.mode == sx7_pkg::CMD_RAW);
                        o_cmd.set_packed = (i_status.mode == sx7_pkg::CMD_PACKED);
                        o_cmd.idx_clr    = 1'b1;
                        n_state = i_status.count_zero ? sx7_pkg::S_IDLE : sx7_pkg::S_GROUP;
                    end
                    sx7_pkg::CMD_FINISH: begin
                        o_cmd.fin     = 1'b1;
                        o_cmd.idx_clr = 1'b1;
                        n_state = i_status.count_zero ? sx7_pkg::S_TAIL : sx7_pkg::S_GROUP;
                    end
                    default: begin
                        o_cmd.clear = 1'b1;
                        n_state     = sx7_pkg::S_IDLE;
                    end
                endcase
            end
            sx7_pkg::S_GROUP: begin
                if (i_status.slot_free) begin
                    o_cmd.emit    = 1'b1;
                    o_cmd.sel     = sx7_pkg::SRC_GROUP;
                    o_cmd.cnt_inc = 1'b1;
                    if (i_status.grp_end) begin
                        o_cmd.group_done = 1'b1;
                        if (i_status.mode == sx7_pkg::CMD_FINISH) begin
                            o_cmd.idx_clr = 1'b1;
                            n_state       = sx7_pkg::S_TAIL;
                        end else begin
                            o_cmd.last = 1'b1;
                            n_state    = sx7_pkg::S_IDLE;
                        end
                    end
                end
            end
            default: begin
                if (i_status.slot_free) begin
                    o_cmd.emit = 1'b1;
                    o_cmd.sel  = sx7_pkg::SRC_TAIL;
                    if (i_status.tail_end) begin
                        o_cmd.last = 1'b1;
                        n_state    = sx7_pkg::S_IDLE;
                    end else begin
                        o_cmd.cnt_inc = 1'b1;
                    end
                end
            end
        endcase
    end

endmodule

// ----- rtl/core/sx7_dp.sv -----
module sx7_dp (
    input  logic                i_clk,
    input  logic                i_rst_n,
    input  logic [2:0]          i_mode,
    input  logic [7:0]          i_data_byte,
    input  logic                i_ready,
    output logic                o_valid,
    output logic [7:0]          o_sysex_byte,
    output logic                o_last,
    input  sx7_pkg::t_dp_cmd    i_cmd,
    output sx7_pkg::t_dp_status o_status
);

    localparam int SW = sx7_pkg::SUM_W;
    localparam int CW = sx7_pkg::CNT_W;

    sx7_pkg::t_cmd r_mode;
    logic [7:0]    r_data;
    logic [6:0]    r_header;
    logic [6:0]    r_low [sx7_pkg::GROUP_SIZE];
    logic [CW-1:0] r_count;
    logic [CW-1:0] r_idx;
    logic          r_packed;
    logic          r_active;
    logic [SW-1:0] r_sum;
    logic [SW-1:0] r_bcount;
    logic [SW-1:0] r_len;
    logic          r_valid;
    logic [7:0]    r_byte;
    logic          r_last;

    logic          slot_free;
    logic [7:0]    group_byte;
    logic [7:0]    tail_byte;
    logic [7:0]    n_byte;
    logic [CW-1:0] low_sel;
    logic [6:0]    hdr_bit;

    assign slot_free = !r_valid || i_ready;
    assign low_sel   = r_idx - CW'(1);
    assign hdr_bit   = r_data[7] ? (7'h40 >> r_count) : 7'h00;

    assign group_byte = (r_idx == '0) ? {1'b0, r_header} : {1'b0, r_low[low_sel]};

    always_comb begin
        case (r_idx)
            sx7_pkg::TAIL_SUM_HI: tail_byte = {1'b0, r_sum[SW-1:7]};
            sx7_pkg::TAIL_SUM_LO: tail_byte = {1'b0, r_sum[6:0]};
            sx7_pkg::TAIL_LEN_HI: tail_byte = {1'b0, r_len[SW-1:7]};
            sx7_pkg::TAIL_LEN_LO: tail_byte = {1'b0, r_len[6:0]};
            default:              tail_byte = sx7_pkg::BYTE_EOX;
        endcase
    end

    always_comb begin
        case (i_cmd.sel)
            sx7_pkg::SRC_RAW:   n_byte = {1'b0, r_data[6:0]};
            sx7_pkg::SRC_BEGIN: n_byte = sx7_pkg::BYTE_SOX;
            sx7_pkg::SRC_GROUP: n_byte = group_byte;
            default:            n_byte = tail_byte;
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (i_cmd.latch) begin
            r_mode <= sx7_pkg::t_cmd'(i_mode);
            r_data <= i_data_byte;
        end
        if (i_cmd.store) begin
            r_low[r_count] <= r_data[6:0];
            r_header       <= (r_count == '0) ? hdr_bit : (r_header | hdr_bit);
        end
        if (i_cmd.emit) begin
            r_byte <= n_byte;
            r_last <= i_cmd.last;
        end
        if (i_cmd.idx_clr) begin
            r_idx <= '0;
        end else if (i_cmd.emit) begin
            r_idx <= r_idx + CW'(1);
        end
        if (i_cmd.fin) begin
            r_len <= r_bcount - sx7_pkg::LEN_OFFSET;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_count  <= '0;
            r_packed <= 1'b1;
            r_active <= 1'b0;
            r_sum    <= '0;
            r_bcount <= '0;
            r_valid  <= 1'b0;
        end else begin
            if (i_cmd.emit) begin
                r_valid <= 1'b1;
            end else if (i_ready) begin
                r_valid <= 1'b0;
            end

            if (i_cmd.clear || i_cmd.group_done) begin
                r_count <= '0;
            end else if (i_cmd.store) begin
                r_count <= r_count + CW'(1);
            end

            if (i_cmd.clear || i_cmd.set_packed) begin
                r_packed <= 1'b1;
            end else if (i_cmd.set_raw || i_cmd.fin) begin
                r_packed <= 1'b0;
            end

            if (i_cmd.clear || i_cmd.fin) begin
                r_active <= 1'b0;
            end else if (i_cmd.sum_start) begin
                r_active <= 1'b1;
            end

            if (i_cmd.clear || i_cmd.sum_start) begin
                r_sum <= '0;
            end else if (i_cmd.emit && r_active &&
                         (i_cmd.sel == sx7_pkg::SRC_RAW || i_cmd.sel == sx7_pkg::SRC_GROUP)) begin
                r_sum <= r_sum + SW'(n_byte);
            end

            if (i_cmd.clear) begin
                r_bcount <= '0;
            end else if (i_cmd.cnt_inc) begin
                r_bcount <= r_bcount + SW'(1);
            end
        end
    end

    assign o_valid      = r_valid;
    assign o_sysex_byte = r_byte;
    assign o_last       = r_last;

    assign o_status.mode        = r_mode;
    assign o_status.packed_mode = r_packed;
    assign o_status.count_zero  = (r_count == '0);
    assign o_status.store_full  = (r_count == CW'(sx7_pkg::GROUP_SIZE - 1));
    assign o_status.grp_end     = (r_idx == r_count);
    assign o_status.tail_end    = (r_idx == sx7_pkg::TAIL_EOX);
    assign o_status.slot_free   = slot_free;

endmodule

// ----- rtl/core/sysex_7bit_packer_with_checksum.sv -----
// MIDI sysex 8-to-7-bit packer with 14-bit checksum.
// Input channel (i_valid/o_ready) carries one command transaction: i_mode and
// i_data_byte. Output channel (o_valid/i_ready) carries one stream byte per
// transaction, o_last marking the final byte caused by a command.
// Commands: data, begin (F0), start sum, flush, raw mode, packed mode,
// finish sum (flush, checksum, length, F7) and clear.
// A command is taken only while the sequencer is idle. The cycle after
// acceptance it executes; raw data and begin emit their byte once the output
// register is free. Group and tail bytes follow, each as soon as the output
// register is free again. The output register lets the next command be
// accepted while the last byte is still waiting.
// A stalled receiver holds o_valid and the byte; the sequencer waits on the
// output register and stops accepting commands until it can finish.
// Reset (i_rst_n low, synchronous) empties the output register, drops any
// partial group, clears checksum and byte count and selects packed mode.
module sysex_7bit_packer_with_checksum (
    input  logic       i_clk,
    input  logic       i_rst_n,
    input  logic       i_valid,
    output logic       o_ready,
    input  logic [2:0] i_mode,
    input  logic [7:0] i_data_byte,
    output logic       o_valid,
    input  logic       i_ready,
    output logic [7:0] o_sysex_byte,
    output logic       o_last
);

    sx7_pkg::t_dp_cmd    cmd;
    sx7_pkg::t_dp_status status;

    sx7_ctrl u_ctrl (
        .i_clk    (i_clk),
        .i_rst_n  (i_rst_n),
        .i_valid  (i_valid),
        .o_ready  (o_ready),
        .i_status (status),
        .o_cmd    (cmd)
    );

    sx7_dp u_dp (
        .i_clk        (i_clk),
        .i_rst_n      (i_rst_n),
        .i_mode       (i_mode),
        .i_data_byte  (i_data_byte),
        .i_ready      (i_ready),
        .o_valid      (o_valid),
        .o_sysex_byte (o_sysex_byte),
        .o_last       (o_last),
        .i_cmd        (cmd),
        .o_status     (status)
    );

endmodule
